FILE: sv/playfair_digraph_cipher_core_assert.svh
// Assertion macros for the Playfair digraph core.
// Depends on clk and rst_n being visible in the module that uses them.
// In synthesis the macros expand to nothing.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PFC_ASSERT_IMP(lbl, ante, cons, msg)

`define PFC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/pfc_pkg.sv
// Shared types, codes and helpers for the Playfair digraph core.
// No dependencies.
package pfc_pkg;

    localparam int SIDE  = 5;
    localparam int IDX_W = 3;

    typedef logic [7:0]       letter_t;
    typedef logic [IDX_W-1:0] coord_t;
    typedef letter_t [SIDE-1:0]          key_row_t;
    typedef key_row_t [SIDE-1:0]         key_square_t;

    localparam coord_t SIDE_LAST = coord_t'(SIDE - 1);

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_MISS_FIRST  = 2'd1;
    localparam logic [1:0] STATUS_MISS_SECOND = 2'd2;

    // Substitution rule chosen by the front end
    localparam logic [1:0] RULE_ROW  = 2'd0;
    localparam logic [1:0] RULE_COL  = 2'd1;
    localparam logic [1:0] RULE_RECT = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_DIRECTION = 3'd0;
    localparam logic [2:0] REG_KEY_ROW0  = 3'd1;
    localparam logic [2:0] REG_KEY_ROW1  = 3'd2;
    localparam logic [2:0] REG_KEY_ROW2  = 3'd3;
    localparam logic [2:0] REG_KEY_ROW3  = 3'd4;
    localparam logic [2:0] REG_KEY_ROW4  = 3'd5;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] rule;
        coord_t     a_row;
        coord_t     a_col;
        coord_t     b_row;
        coord_t     b_col;
    } pfc_item_t;

    // Move one place along a row or column, wrapping round the square
    function automatic coord_t pfc_move(coord_t v, logic back);
        coord_t res;
        if (back)
        begin
            res = (v == '0) ? SIDE_LAST : coord_t'(v - coord_t'(1));
        end
        else
        begin
            res = (v == SIDE_LAST) ? '0 : coord_t'(v + coord_t'(1));
        end
        return res;
    endfunction

endpackage

FILE: sv/playfair_digraph_cipher_core.sv
// Path: an accepted pair passes the classify register, the queue write and the output
// register before it can be popped; a full queue or an unpopped result stalls it.
// Throughput: one pair per cycle unless full; a QUEUE_DEPTH-entry queue decouples stalls.
// Reset: rst_n asynchronous, active low; clears direction, key square and the queue.
// Top level of the Playfair digraph core: configuration registers and the
// front, queue and back-end instances. Depends on pfc_pkg and its submodules.
module playfair_digraph_cipher_core import pfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] first_letter,
    input  logic [7:0] second_letter,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] first_out,
    output logic [7:0] second_out,
    output logic [1:0] status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [39:0] cfg_data
);

    logic        direction_reg;
    logic        direction_next;
    key_square_t square_reg;
    key_square_t square_next;
    logic        cfg_we;

    logic        fq_valid;
    logic        fq_ready;
    pfc_item_t   fq_item;
    logic        qb_valid;
    logic        qb_ready;
    pfc_item_t   qb_item;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        direction_next = direction_reg;
        square_next    = square_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIRECTION: direction_next = cfg_data[0];
                REG_KEY_ROW0:  square_next[0] = cfg_data;
                REG_KEY_ROW1:  square_next[1] = cfg_data;
                REG_KEY_ROW2:  square_next[2] = cfg_data;
                REG_KEY_ROW3:  square_next[3] = cfg_data;
                REG_KEY_ROW4:  square_next[4] = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            square_reg    <= '0;
        end
        else
        begin
            direction_reg <= direction_next;
            square_reg    <= square_next;
        end
    end

    pfc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .first_letter  (first_letter),
        .second_letter (second_letter),
        .square        (square_reg),
        .item_valid    (fq_valid),
        .item          (fq_item),
        .item_ready    (fq_ready)
    );

    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    pfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .square     (square_reg),
        .direction  (direction_reg),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .empty      (empty),
        .pop        (pop),
        .first_out  (first_out),
        .second_out (second_out),
        .status     (status)
    );

endmodule

FILE: sv/pfc_front.sv
// Front end: locates both letters in the key square and classifies the rule.
// Depends on pfc_pkg.
module pfc_front import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  letter_t     first_letter,
    input  letter_t     second_letter,
    input  key_square_t square,
    output logic        item_valid,
    output pfc_item_t   item,
    input  logic        item_ready
);

    logic      stage_valid_reg;
    logic      stage_valid_next;
    pfc_item_t stage_item_reg;
    pfc_item_t stage_item_next;
    logic      accept;

    logic   found_a;
    logic   found_b;
    coord_t a_row;
    coord_t a_col;
    coord_t b_row;
    coord_t b_col;

    // Scan in row-major order; later hits overwrite earlier ones
    always_comb
    begin
        found_a = 1'b0;
        found_b = 1'b0;
        a_row   = '0;
        a_col   = '0;
        b_row   = '0;
        b_col   = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (square[r][c] == first_letter)
                begin
                    found_a = 1'b1;
                    a_row   = coord_t'(r);
                    a_col   = coord_t'(c);
                end
                else if (square[r][c] == second_letter)
                begin
                    found_b = 1'b1;
                    b_row   = coord_t'(r);
                    b_col   = coord_t'(c);
                end
            end
        end
    end

    always_comb
    begin
        stage_item_next.a_row = a_row;
        stage_item_next.a_col = a_col;
        stage_item_next.b_row = b_row;
        stage_item_next.b_col = b_col;
        priority if (!found_a)
        begin
            stage_item_next.status = STATUS_MISS_FIRST;
        end
        else if (!found_b)
        begin
            stage_item_next.status = STATUS_MISS_SECOND;
        end
        else
        begin
            stage_item_next.status = STATUS_OK;
        end
        priority if (a_row == b_row)
        begin
            stage_item_next.rule = RULE_ROW;
        end
        else if (a_col == b_col)
        begin
            stage_item_next.rule = RULE_COL;
        end
        else
        begin
            stage_item_next.rule = RULE_RECT;
        end
    end

    // Stage stays loaded while the queue is full
    assign full   = stage_valid_reg && !item_ready;
    assign accept = push && !full;

    always_comb
    begin
        priority if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= stage_item_next;
        end
    end

    assign item_valid = stage_valid_reg;
    assign item       = stage_item_reg;

endmodule

FILE: sv/pfc_queue.sv
// Short queue of classified transactions between front and back end.
// Depends on pfc_pkg and the assertion macro header.
`include "playfair_digraph_cipher_core_assert.svh"
module pfc_queue import pfc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  pfc_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output pfc_item_t rd_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    pfc_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;
    logic             rd_en;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    `PFC_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")
    `PFC_ASSERT_NXT(a_count_up, wr_en && !rd_en, count_reg == CNT_W'($past(count_reg) + 1'b1), "queue count did not advance on write")
    `PFC_ASSERT_IMP(a_ptr_match, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "queue pointers differ while empty")

endmodule

FILE: sv/pfc_back.sv
// Back end: applies the Playfair rule and holds the result for the consumer.
// Depends on pfc_pkg and the assertion macro header.
`include "playfair_digraph_cipher_core_assert.svh"
module pfc_back import pfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_square_t square,
    input  logic        direction,
    input  logic        item_valid,
    output logic        item_ready,
    input  pfc_item_t   item,
    output logic        empty,
    input  logic        pop,
    output letter_t     first_out,
    output letter_t     second_out,
    output logic [1:0]  status
);

    logic       out_valid_reg;
    logic       out_valid_next;
    letter_t    first_reg;
    letter_t    first_next;
    letter_t    second_reg;
    letter_t    second_next;
    logic [1:0] status_reg;
    logic       take;
    coord_t     fa_row;
    coord_t     fa_col;
    coord_t     fb_row;
    coord_t     fb_col;

    // Output slot frees when empty or when the held transaction is popped
    assign item_ready = !out_valid_reg || pop;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        fa_row = item.a_row;
        fa_col = item.a_col;
        fb_row = item.b_row;
        fb_col = item.b_col;
        unique case (item.rule)
            RULE_ROW:
            begin
                fa_col = pfc_move(item.a_col, direction);
                fb_col = pfc_move(item.b_col, direction);
            end
            RULE_COL:
            begin
                fa_row = pfc_move(item.a_row, direction);
                fb_row = pfc_move(item.b_row, direction);
            end
            RULE_RECT:
            begin
                fa_col = item.b_col;
                fb_col = item.a_col;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (item.status == STATUS_OK)
        begin
            first_next  = square[fa_row][fa_col];
            second_next = square[fb_row][fb_col];
        end
        else
        begin
            first_next  = '0;
            second_next = '0;
        end
    end

    always_comb
    begin
        priority if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            status_reg <= item.status;
        end
    end

    assign empty      = !out_valid_reg;
    assign first_out  = first_reg;
    assign second_out = second_reg;
    assign status     = status_reg;

    `PFC_ASSERT_IMP(a_err_zero, out_valid_reg && (status_reg != STATUS_OK), (first_reg == '0) && (second_reg == '0), "nonzero status with nonzero letters")
    `PFC_ASSERT_IMP(a_take_slot, take, !out_valid_reg || pop, "result overwritten before pop")
    `PFC_ASSERT_NXT(a_take_valid, take, out_valid_reg, "taken transaction not presented")

endmodule

FILE: dv/playfair_digraph_cipher_core_tb.sv
// Self-checking testbench for playfair_digraph_cipher_core: directed and random letter
// pairs over several key squares and both directions, with random stalls on both sides.
// Depends on pfc_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
    import pfc_pkg::*;

    typedef logic [2:0] reg_index_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
    } letter_pair_t;

    typedef struct packed {
        letter_t    first;
        letter_t    second;
        logic [1:0] status;
    } substitution_t;

    typedef enum int { SQ_DISTINCT, SQ_REPEATS, SQ_ALL_ONES, SQ_ZERO } square_kind_e;

    localparam reg_index_t REG_SPARE_LO = REG_KEY_ROW4 + 3'd1;
    localparam reg_index_t REG_SPARE_HI = 3'd7;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_PHASES = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    letter_t     first_letter = '0;
    letter_t     second_letter = '0;
    logic        empty;
    logic        pop = 1'b0;
    letter_t     first_out;
    letter_t     second_out;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    reg_index_t  cfg_index = '0;
    logic [39:0] cfg_data = '0;

    // Copy of the block's configuration, updated on each accepted write
    letter_t key_sq [SIDE][SIDE];
    logic    decrypt;
    letter_t plan_sq [SIDE][SIDE];

    letter_pair_t  pair_q[$];
    substitution_t expected_q[$];

    int send_gap = 0;
    int pop_stall = 0;
    int send_gap_pct = 0;
    int pop_stall_pct = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    playfair_digraph_cipher_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .first_letter  (first_letter),
        .second_letter (second_letter),
        .empty         (empty),
        .pop           (pop),
        .first_out     (first_out),
        .second_out    (second_out),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int shift_one(int v);
        return decrypt ? (v + SIDE - 1) % SIDE : (v + 1) % SIDE;
    endfunction

    function automatic substitution_t substitute(letter_t a, letter_t b);
        bit found_a;
        bit found_b;
        int ar;
        int ac;
        int br;
        int bc;
        substitution_t res;
        found_a = 1'b0;
        found_b = 1'b0;
        ar = 0;
        ac = 0;
        br = 0;
        bc = 0;
        res = '0;
        // Scan in row-major order; the last match wins, and a cell is tested
        // against the first letter before the second
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (key_sq[r][c] == a)
                begin
                    found_a = 1'b1;
                    ar = r;
                    ac = c;
                end
                else if (key_sq[r][c] == b)
                begin
                    found_b = 1'b1;
                    br = r;
                    bc = c;
                end
            end
        end
        if (!found_a)
            res.status = STATUS_MISS_FIRST;
        else if (!found_b)
            res.status = STATUS_MISS_SECOND;
        else
        begin
            res.status = STATUS_OK;
            if (ar == br)
            begin
                res.first  = key_sq[ar][shift_one(ac)];
                res.second = key_sq[br][shift_one(bc)];
            end
            else if (ac == bc)
            begin
                res.first  = key_sq[shift_one(ar)][ac];
                res.second = key_sq[shift_one(br)][bc];
            end
            else
            begin
                res.first  = key_sq[ar][bc];
                res.second = key_sq[br][ac];
            end
        end
        return res;
    endfunction

    // Sender: present queued pairs, predict each one as its transaction completes
    always @(posedge clk or negedge rst_n)
    begin : sender
        letter_pair_t nxt;
        if (!rst_n)
        begin
            push <= 1'b0;
            first_letter <= '0;
            second_letter <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (push && !full)
                expected_q.push_back(substitute(first_letter, second_letter));
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    push <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pair_q.size() == 0)
                    push <= 1'b0;
                else if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
                begin
                    push <= 1'b0;
                    send_gap <= $urandom_range(8);
                end
                else
                begin
                    nxt = pair_q.pop_front();
                    push <= 1'b1;
                    first_letter <= nxt.first;
                    second_letter <= nxt.second;
                end
            end
        end
    end

    // Receiver: check each popped result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : receiver
        substitution_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_stall <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: first_out %0h second_out %0h status %0d",
                           first_out, second_out, status);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (first_out !== want.first)
                    begin
                        $error("first_out: expected %0h, got %0h", want.first, first_out);
                        mismatches++;
                    end
                    if (second_out !== want.second)
                    begin
                        $error("second_out: expected %0h, got %0h", want.second, second_out);
                        mismatches++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                end
            end
            if (pop_stall > 0)
            begin
                pop <= 1'b0;
                pop_stall <= pop_stall - 1;
            end
            else if (pop_stall_pct > 0 && $urandom_range(99) < pop_stall_pct)
            begin
                pop <= 1'b0;
                pop_stall <= $urandom_range(8);
            end
            else
                pop <= 1'b1;
        end
    end

    // Abort if no transaction of any kind completes for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [39:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_DIRECTION)
            decrypt = val[0];
        else if (idx >= REG_KEY_ROW0 && idx <= REG_KEY_ROW4)
        begin
            for (int c = 0; c < SIDE; c++)
                key_sq[idx - REG_KEY_ROW0][c] = val[8*c +: 8];
        end
    endtask

    // Hold until every pair is through and every result popped, then let the pipe settle.
    // Sample between edges so that the sender's updates at the edge have landed.
    task automatic wait_idle();
        @(negedge clk);
        while (pair_q.size() != 0 || push || expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic build_square(input square_kind_e kind);
        bit      taken [256];
        letter_t alphabet [6];
        letter_t v;
        foreach (alphabet[k])
            alphabet[k] = letter_t'($urandom_range(255));
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                case (kind)
                    SQ_DISTINCT:
                    begin
                        do
                            v = letter_t'($urandom_range(255));
                        while (taken[v]);
                        taken[v] = 1'b1;
                        plan_sq[r][c] = v;
                    end
                    SQ_REPEATS:  plan_sq[r][c] = alphabet[$urandom_range(5)];
                    SQ_ALL_ONES: plan_sq[r][c] = 8'hFF;
                    default:     plan_sq[r][c] = 8'h00;
                endcase
            end
        end
    endtask

    // Write direction first, then all five rows in a random order, sometimes a spare index too
    task automatic program_square(input logic dir);
        int          order [SIDE];
        int          j;
        int          t;
        logic [39:0] val;
        for (int k = 0; k < SIDE; k++)
            order[k] = k;
        for (int k = SIDE - 1; k > 0; k--)
        begin
            j = $urandom_range(k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        // Upper bits of the direction data must be dropped by the block
        val = 40'({$urandom(), $urandom()});
        val[0] = dir;
        write_reg(REG_DIRECTION, val);
        for (int k = 0; k < SIDE; k++)
        begin
            for (int c = 0; c < SIDE; c++)
                val[8*c +: 8] = plan_sq[order[k]][c];
            write_reg(reg_index_t'(REG_KEY_ROW0 + order[k]), val);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                          40'({$urandom(), $urandom()}));
        end
    endtask

    task automatic add_pair(input letter_t a, input letter_t b);
        letter_pair_t p;
        p.first = a;
        p.second = b;
        pair_q.push_back(p);
    endtask

    task automatic add_cells(input int r1, input int c1, input int r2, input int c2);
        add_pair(key_sq[r1][c1], key_sq[r2][c2]);
    endtask

    task automatic queue_directed();
        add_cells(0, 0, 0, 4);
        add_cells(0, 1, 0, 2);
        add_cells(0, 0, 4, 0);
        add_cells(1, 2, 3, 2);
        add_cells(0, 0, 4, 4);
        add_cells(1, 1, 2, 3);
        // Letter held twice: it resolves to its later cell, sharing a row with the partner
        add_cells(1, 3, 3, 4);
        add_cells(2, 2, 2, 2);
        add_pair(8'h80, key_sq[2][0]);
        add_pair(key_sq[2][0], 8'h80);
        add_pair(8'h7F, 8'hFE);
    endtask

    task automatic queue_random(input int n);
        int r1;
        int c1;
        int r2;
        int c2;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            r1 = $urandom_range(SIDE - 1);
            c1 = $urandom_range(SIDE - 1);
            r2 = $urandom_range(SIDE - 1);
            c2 = $urandom_range(SIDE - 1);
            if (pick < 30)
                add_cells(r1, c1, r1, (c1 + 1 + $urandom_range(SIDE - 2)) % SIDE);
            else if (pick < 55)
                add_cells(r1, c1, (r1 + 1 + $urandom_range(SIDE - 2)) % SIDE, c1);
            else if (pick < 75)
                add_cells(r1, c1, r2, c2);
            else if (pick < 82)
                add_cells(r1, c1, r1, c1);
            else if (pick < 88)
                add_pair(letter_t'($urandom_range(255)), key_sq[r2][c2]);
            else if (pick < 94)
                add_pair(key_sq[r1][c1], letter_t'($urandom_range(255)));
            else
                add_pair(letter_t'($urandom_range(255)), letter_t'($urandom_range(255)));
        end
    endtask

    function automatic int pick_pct();
        int levels [4] = '{0, 15, 40, 70};
        return levels[$urandom_range(3)];
    endfunction

    initial
    begin
        square_kind_e kinds [RANDOM_PHASES] = '{SQ_DISTINCT, SQ_REPEATS, SQ_DISTINCT,
                                                SQ_ALL_ONES, SQ_DISTINCT, SQ_REPEATS,
                                                SQ_ZERO, SQ_DISTINCT, SQ_DISTINCT,
                                                SQ_DISTINCT};
        decrypt = 1'b0;
        foreach (key_sq[r, c])
            key_sq[r][c] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: every cell holds zero
        send_gap_pct = 30;
        pop_stall_pct = 30;
        add_pair(8'h00, 8'h00);
        add_pair(8'h00, 8'h41);
        add_pair(8'hFF, 8'h00);
        wait_idle();

        // Directed square with both extreme bytes and one letter held twice
        foreach (plan_sq[r, c])
            plan_sq[r][c] = letter_t'(8'h41 + 5 * r + c);
        plan_sq[0][0] = 8'h00;
        plan_sq[4][4] = 8'hFF;
        plan_sq[3][1] = plan_sq[1][3];
        program_square(1'b0);
        queue_directed();
        wait_idle();
        write_reg(REG_DIRECTION, 40'h1);
        queue_directed();
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p >= RANDOM_PHASES - 2)
            begin
                send_gap_pct = 0;
                pop_stall_pct = 0;
            end
            else
            begin
                send_gap_pct = pick_pct();
                pop_stall_pct = pick_pct();
            end
            build_square(kinds[p]);
            program_square(p[0]);
            queue_random((kinds[p] == SQ_ALL_ONES || kinds[p] == SQ_ZERO) ? 20 : 130);
            wait_idle();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
